FILE: sv/assert_macros.svh
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational condition checked at every edge outside reset
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: sv/dmr_pkg.sv
`default_nettype none

package dmr_pkg;

	localparam int QUEUE_DEPTH  = 4096;
	localparam int MAX_CHANNELS = 8;
	localparam int CHAN_FIELDS  = 8;

	localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
	localparam int COUNT_W  = 13;
	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = 4;
	localparam int REQ_W    = 2;

	// sum of up to eight 16-bit samples, and its magnitude
	localparam int SUM_W = SAMPLE_W + $clog2(CHAN_FIELDS);
	localparam int MAG_W = SUM_W;

	// divide by channel count as multiply by ceil(2^SHIFT / count)
	localparam int RECIP_SHIFT = MAG_W + 1;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = MAG_W + RECIP_W;

	localparam int QUEUE_SLOTS = 2;
	localparam int SLOT_W      = $clog2(QUEUE_SLOTS);

	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_CLEAR,
		OP_REJECT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [CNT_W-1:0] chans;
	} cmd_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
		logic [RECIP_W-1:0] r;
		case (c)
			4'd1:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 1);
			4'd2:    r = RECIP_W'(((64'd1 << RECIP_SHIFT) + 1) / 2);
			4'd3:    r = RECIP_W'(((64'd1 << RECIP_SHIFT) + 2) / 3);
			4'd4:    r = RECIP_W'(((64'd1 << RECIP_SHIFT) + 3) / 4);
			4'd5:    r = RECIP_W'(((64'd1 << RECIP_SHIFT) + 4) / 5);
			4'd6:    r = RECIP_W'(((64'd1 << RECIP_SHIFT) + 5) / 6);
			4'd7:    r = RECIP_W'(((64'd1 << RECIP_SHIFT) + 6) / 7);
			4'd8:    r = RECIP_W'(((64'd1 << RECIP_SHIFT) + 7) / 8);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
		return (idx == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

endpackage

`default_nettype wire

FILE: sv/dmr_if.sv
`default_nettype none

interface dmr_req_if;
	import dmr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [REQ_W-1:0]           req_type;
	logic [CNT_W-1:0]           channel_count;
	logic signed [SAMPLE_W-1:0] chan0;
	logic signed [SAMPLE_W-1:0] chan1;
	logic signed [SAMPLE_W-1:0] chan2;
	logic signed [SAMPLE_W-1:0] chan3;
	logic signed [SAMPLE_W-1:0] chan4;
	logic signed [SAMPLE_W-1:0] chan5;
	logic signed [SAMPLE_W-1:0] chan6;
	logic signed [SAMPLE_W-1:0] chan7;

	modport source (
		output valid, req_type, channel_count,
		output chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7,
		input  ready
	);
	modport sink (
		input  valid, req_type, channel_count,
		input  chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7,
		output ready
	);
endinterface

interface dmr_rsp_if;
	import dmr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic signed [SAMPLE_W-1:0] read_sample;
	logic                       underrun;
	logic                       dropped;
	logic [COUNT_W-1:0]         fill_level;

	modport source (
		output valid, accepted, read_sample, underrun, dropped, fill_level,
		input  ready
	);
	modport sink (
		input  valid, accepted, read_sample, underrun, dropped, fill_level,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/dmr_ram.sv
`default_nettype none

module dmr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/dmr_front.sv
`default_nettype none

module dmr_front import dmr_pkg::*; (
	dmr_req_if.sink    req,
	output cmd_t       cmd,
	output logic       cmd_valid,
	input  wire logic  cmd_ready
);

	logic signed [SAMPLE_W-1:0] chans [CHAN_FIELDS];
	logic signed [SUM_W-1:0]    sum;
	logic                       count_ok;

	assign chans[0] = req.chan0;
	assign chans[1] = req.chan1;
	assign chans[2] = req.chan2;
	assign chans[3] = req.chan3;
	assign chans[4] = req.chan4;
	assign chans[5] = req.chan5;
	assign chans[6] = req.chan6;
	assign chans[7] = req.chan7;

	assign count_ok = (req.channel_count != '0) &&
		(req.channel_count <= CNT_W'(MAX_CHANNELS));

	// channels at or above the count add nothing
	always_comb begin
		sum = '0;
		for (int i = 0; i < CHAN_FIELDS; i++) begin
			if (i < int'(req.channel_count)) begin
				sum = sum + SUM_W'(chans[i]);
			end
		end
	end

	always_comb begin
		cmd.neg   = sum[SUM_W-1];
		cmd.mag   = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
		cmd.chans = req.channel_count;
		unique case (req.req_type)
			REQ_WRITE: cmd.op = count_ok ? OP_WRITE : OP_REJECT;
			REQ_READ:  cmd.op = OP_READ;
			REQ_CLEAR: cmd.op = OP_CLEAR;
			default:   cmd.op = OP_REJECT;
		endcase
	end

	assign cmd_valid = req.valid;
	assign req.ready = cmd_ready;

endmodule

`default_nettype wire

FILE: sv/dmr_queue.sv
`default_nettype none

module dmr_queue import dmr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t in_cmd,
	input  wire logic in_valid,
	output logic      in_ready,
	output cmd_t      out_cmd,
	output logic      out_valid,
	input  wire logic out_ready
);

	cmd_t              slot_q [QUEUE_SLOTS];
	logic [SLOT_W-1:0] wr_ptr_q;
	logic [SLOT_W-1:0] rd_ptr_q;
	logic [SLOT_W:0]   used_q;
	logic              push;
	logic              pop;

	assign in_ready  = (used_q != (SLOT_W + 1)'(QUEUE_SLOTS));
	assign out_valid = (used_q != '0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   used_q <= used_q + 1'b1;
				2'b01:   used_q <= used_q - 1'b1;
				default: used_q <= used_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/dmr_back.sv
`default_nettype none

module dmr_back import dmr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   cmd,
	input  wire logic   cmd_valid,
	output logic        cmd_ready,
	dmr_rsp_if.source   rsp
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MUL   = 4'b0010,
		ST_FIX   = 4'b0100,
		ST_RDATA = 4'b1000
	} state_t;

	state_t              state_q;
	logic                neg_q;
	logic [MAG_W-1:0]    mag_q;
	logic [CNT_W-1:0]    chans_q;
	logic [PROD_W-1:0]   prod_q;
	logic [ADDR_W-1:0]   head_q;
	logic [ADDR_W-1:0]   tail_q;
	logic [COUNT_W-1:0]  count_q;

	logic                out_valid_q;
	logic                out_accepted_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic                out_underrun_q;
	logic                out_dropped_q;
	logic [COUNT_W-1:0]  out_fill_q;

	logic                pop;
	logic                full;
	logic                ram_we;
	logic                ram_re;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic [MAG_W-1:0]    q_est;
	logic [MAG_W+CNT_W-1:0] q_check;
	logic [MAG_W-1:0]    q_fix;
	logic [MAG_W-1:0]    q_signed;
	logic [SAMPLE_W-1:0] mono;

	assign cmd_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign pop       = cmd_ready && cmd_valid;
	assign full      = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign ram_re    = pop && (cmd.op == OP_READ) && (count_q != '0);
	assign ram_we    = (state_q == ST_FIX);

	// reciprocal estimate is exact or one too high
	always_comb begin
		q_est    = prod_q[RECIP_SHIFT +: MAG_W];
		q_check  = (MAG_W + CNT_W)'(q_est) * (MAG_W + CNT_W)'(chans_q);
		q_fix    = (q_check > (MAG_W + CNT_W)'(mag_q)) ? q_est - 1'b1 : q_est;
		q_signed = neg_q ? (MAG_W'(0) - q_fix) : q_fix;
		mono     = q_signed[SAMPLE_W-1:0];
	end

	dmr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (mono),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			neg_q          <= 1'b0;
			mag_q          <= '0;
			chans_q        <= '0;
			prod_q         <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			count_q        <= '0;
			out_valid_q    <= 1'b0;
			out_accepted_q <= 1'b0;
			out_sample_q   <= '0;
			out_underrun_q <= 1'b0;
			out_dropped_q  <= 1'b0;
			out_fill_q     <= '0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						neg_q          <= cmd.neg;
						mag_q          <= cmd.mag;
						chans_q        <= cmd.chans;
						out_accepted_q <= 1'b1;
						out_sample_q   <= '0;
						out_underrun_q <= 1'b0;
						out_dropped_q  <= 1'b0;
						case (cmd.op)
							OP_WRITE: begin
								state_q <= ST_MUL;
							end
							OP_READ: begin
								if (count_q == '0) begin
									out_underrun_q <= 1'b1;
									out_fill_q     <= '0;
									out_valid_q    <= 1'b1;
								end else begin
									head_q  <= ring_next(head_q);
									count_q <= count_q - 1'b1;
									state_q <= ST_RDATA;
								end
							end
							OP_CLEAR: begin
								head_q      <= '0;
								tail_q      <= '0;
								count_q     <= '0;
								out_fill_q  <= '0;
								out_valid_q <= 1'b1;
							end
							default: begin
								out_accepted_q <= 1'b0;
								out_fill_q     <= count_q;
								out_valid_q    <= 1'b1;
							end
						endcase
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(mag_q) * PROD_W'(recip(chans_q));
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					// full ring drops the oldest before storing
					tail_q <= ring_next(tail_q);
					if (full) begin
						head_q        <= ring_next(head_q);
						out_dropped_q <= 1'b1;
						out_fill_q    <= count_q;
					end else begin
						count_q    <= count_q + 1'b1;
						out_fill_q <= count_q + 1'b1;
					end
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_RDATA: begin
					out_sample_q <= ram_rdata;
					out_fill_q   <= count_q;
					out_valid_q  <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.accepted    = out_accepted_q;
	assign rsp.read_sample = out_sample_q;
	assign rsp.underrun    = out_underrun_q;
	assign rsp.dropped     = out_dropped_q;
	assign rsp.fill_level  = out_fill_q;

endmodule

`default_nettype wire

FILE: sv/downmix_overwrite_pcm_ring.sv
// Downmixing playout sample queue over a 4096-entry overwrite-oldest ring.
// Requests come in on req (valid/ready): write one frame, read one sample,
// or clear. A write averages the first channel_count channels (1 to 8),
// truncating toward zero, and appends the mono sample; a full ring loses
// its oldest sample and the response carries dropped. A read returns the
// oldest sample, or zero with underrun when the ring is empty.
// Every request yields exactly one response on rsp (valid/ready).
// A request passes through the request queue; clear and rejected
// requests are answered from the back end's idle state, a read
// goes through a registered ram read, and a write through a reciprocal
// multiply, then a one-step correction.
// The back end runs one request at a time and takes the next one only
// after rsp has taken the previous response.
// A two-entry request queue sits in front, so req keeps being accepted
// while a response waits; when rsp stalls the queue fills and req.ready
// drops until the response is taken.
// Reset empties the ring at once (pointers and count); no clearing pass.

`default_nettype none

`include "assert_macros.svh"

module downmix_overwrite_pcm_ring import dmr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dmr_req_if.sink    req,
	dmr_rsp_if.source  rsp
);

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	dmr_front u_front (
		.req       (req),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	dmr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (front_cmd),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.out_cmd   (back_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready)
	);

	dmr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.rsp       (rsp)
	);

	`ASSERT_IMPLIES(a_underrun_empty, clk, arst_n, rsp.valid && rsp.underrun,
		rsp.accepted && (rsp.fill_level == '0) && (rsp.read_sample == '0),
		"underrun with nonempty ring or nonzero sample")
	`ASSERT_IMPLIES(a_drop_full, clk, arst_n, rsp.valid && rsp.dropped,
		rsp.accepted && (rsp.fill_level == COUNT_W'(QUEUE_DEPTH)) && !rsp.underrun,
		"drop reported without a full ring")
	`ASSERT_IMPLIES(a_reject_clean, clk, arst_n, rsp.valid && !rsp.accepted,
		!rsp.underrun && !rsp.dropped && (rsp.read_sample == '0),
		"rejected request carries flags or data")
	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n,
		!rsp.valid || (rsp.fill_level <= COUNT_W'(QUEUE_DEPTH)),
		"fill level beyond ring depth")

endmodule

`default_nettype wire

FILE: tb/downmix_overwrite_pcm_ring_tb.sv
`default_nettype none

module downmix_overwrite_pcm_ring_tb;
	import dmr_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [REQ_W-1:0]              kind;
		logic [CNT_W-1:0]              chans;
		logic [7:0][SAMPLE_W-1:0]      ch;
	} pcm_request_t;

	typedef struct packed {
		logic                accepted;
		logic [SAMPLE_W-1:0] sample;
		logic                underrun;
		logic                dropped;
		logic [COUNT_W-1:0]  fill;
	} pcm_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dmr_req_if req_bus ();
	dmr_rsp_if rsp_bus ();

	downmix_overwrite_pcm_ring dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the ring
	logic [SAMPLE_W-1:0] pcm_ring [QUEUE_DEPTH];
	int ring_head;
	int ring_tail;
	int ring_count;

	pcm_result_t expected_results [$];

	int req_gap_max;
	int rsp_stall_max;
	int mismatches;
	int cycle_count;
	int responses_seen;
	int carried_out;
	int n_writes, n_drops, n_reads, n_underruns, n_clears, n_refused;

	function automatic int ring_step(input int idx);
		return (idx + 1) % QUEUE_DEPTH;
	endfunction

	// mean of the first count channels, truncated toward zero
	function automatic logic [SAMPLE_W-1:0] average_channels(
		input logic [7:0][SAMPLE_W-1:0] ch, input int count);
		int acc;
		int mag;
		int q;
		acc = 0;
		for (int c = 0; c < count && c < 8; c++)
			acc += int'($signed(ch[c]));
		mag = (acc < 0) ? -acc : acc;
		q = mag / count;
		if (acc < 0)
			q = -q;
		return q[SAMPLE_W-1:0];
	endfunction

	function automatic pcm_result_t predict_playout(input pcm_request_t it);
		pcm_result_t r;
		logic [SAMPLE_W-1:0] mono;
		r = '0;
		case (it.kind)
			REQ_WRITE: begin
				if (it.chans >= 1 && it.chans <= MAX_CHANNELS) begin
					mono = average_channels(it.ch, int'(it.chans));
					if (ring_count >= QUEUE_DEPTH) begin
						ring_head = ring_step(ring_head);
						ring_count--;
						r.dropped = 1'b1;
						n_drops++;
					end
					pcm_ring[ring_tail] = mono;
					ring_tail = ring_step(ring_tail);
					ring_count++;
					r.accepted = 1'b1;
					n_writes++;
				end
			end
			REQ_READ: begin
				r.accepted = 1'b1;
				n_reads++;
				if (ring_count == 0) begin
					r.underrun = 1'b1;
					n_underruns++;
				end else begin
					r.sample = pcm_ring[ring_head];
					ring_head = ring_step(ring_head);
					ring_count--;
				end
			end
			REQ_CLEAR: begin
				ring_head = 0;
				ring_tail = 0;
				ring_count = 0;
				r.accepted = 1'b1;
				n_clears++;
			end
			default: ;
		endcase
		if (r.accepted)
			carried_out++;
		else
			n_refused++;
		r.fill = ring_count[COUNT_W-1:0];
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 11))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'hffff;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic pcm_request_t random_item(input logic [REQ_W-1:0] kind);
		pcm_request_t it;
		int v;
		it.kind = kind;
		for (int c = 0; c < 8; c++)
			it.ch[c] = random_sample();
		if (kind == REQ_WRITE) begin
			if ($urandom_range(0, 9) != 0) begin
				it.chans = CNT_W'($urandom_range(1, MAX_CHANNELS));
			end else begin
				v = $urandom_range(MAX_CHANNELS, 15);
				it.chans = (v == MAX_CHANNELS) ? '0 : CNT_W'(v);
			end
		end else begin
			it.chans = CNT_W'($urandom_range(0, 15));
		end
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at response %0d: %s", responses_seen, msg);
		mismatches++;
	endtask

	task automatic send_request(input pcm_request_t it);
		int gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid         <= 1'b1;
		req_bus.req_type      <= it.kind;
		req_bus.channel_count <= it.chans;
		req_bus.chan0         <= it.ch[0];
		req_bus.chan1         <= it.ch[1];
		req_bus.chan2         <= it.ch[2];
		req_bus.chan3         <= it.ch[3];
		req_bus.chan4         <= it.ch[4];
		req_bus.chan5         <= it.ch[5];
		req_bus.chan6         <= it.ch[6];
		req_bus.chan7         <= it.ch[7];
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		expected_results.push_back(predict_playout(it));
	endtask

	task automatic send_write(input int count, input int s0, input int s1, input int s2,
		input int s3, input int s4, input int s5, input int s6, input int s7);
		pcm_request_t it;
		it.kind  = REQ_WRITE;
		it.chans = CNT_W'(count);
		it.ch[0] = SAMPLE_W'(s0);
		it.ch[1] = SAMPLE_W'(s1);
		it.ch[2] = SAMPLE_W'(s2);
		it.ch[3] = SAMPLE_W'(s3);
		it.ch[4] = SAMPLE_W'(s4);
		it.ch[5] = SAMPLE_W'(s5);
		it.ch[6] = SAMPLE_W'(s6);
		it.ch[7] = SAMPLE_W'(s7);
		send_request(it);
	endtask

	// sender holds off until every response is back
	task automatic wait_for_results();
		req_bus.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		req_gap_max   = 3;
		rsp_stall_max = 3;
		send_request(random_item(REQ_READ));
		send_write(1, 32767, 0, 0, 0, 0, 0, 0, 0);
		send_write(8, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_write(8, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_write(3, -5, 0, 0, 1234, -999, 7, 7, 7);
		send_write(3, 5, 0, 0, -1, -1, -1, -1, -1);
		send_write(7, 32767, -32768, 100, -100, 1, 2, 3, 32767);
		send_write(2, -1, 0, -32768, -32768, -32768, -32768, -32768, -32768);
		// counts outside 1..8 are refused
		send_write(0, 100, 100, 100, 100, 100, 100, 100, 100);
		send_write(9, -1, -1, -1, -1, -1, -1, -1, -1);
		send_write(15, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_request(random_item(REQ_UNUSED));
		repeat (8) send_request(random_item(REQ_READ));
		send_write(5, -32768, 32767, -32768, 32767, -32768, 1, 1, 1);
		send_request(random_item(REQ_CLEAR));
		send_request(random_item(REQ_READ));
		send_write(6, 1000, -3000, 5, 5, 5, 5, 9, 9);
		send_request(random_item(REQ_READ));
		wait_for_results();
	endtask

	task automatic test_full_ring_overwrite();
		pcm_request_t it;
		send_request(random_item(REQ_CLEAR));
		req_gap_max   = 0;
		rsp_stall_max = 0;
		while (ring_count < QUEUE_DEPTH)
			send_request(random_item(REQ_WRITE));
		req_gap_max   = 10;
		rsp_stall_max = 10;
		// writes into a full ring push out the oldest sample
		repeat (40) send_request(random_item(REQ_WRITE));
		send_request(random_item(REQ_UNUSED));
		repeat (60) begin
			it = random_item(($urandom_range(0, 1) != 0) ? REQ_READ : REQ_WRITE);
			send_request(it);
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		int start;
		int seg_len;
		int seg_kind;
		int r;
		int segments;
		start = carried_out;
		segments = 0;
		while (carried_out - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				req_gap_max   = 0;
				rsp_stall_max = 0;
			end else begin
				req_gap_max   = $urandom_range(0, 10);
				rsp_stall_max = $urandom_range(0, 10);
			end
			seg_len  = $urandom_range(5, 60);
			seg_kind = $urandom_range(0, 9);
			if (seg_kind <= 3) begin
				repeat (seg_len) begin
					r = $urandom_range(0, 99);
					if (r < 46)
						send_request(random_item(REQ_WRITE));
					else if (r < 88)
						send_request(random_item(REQ_READ));
					else if (r < 94)
						send_request(random_item(REQ_CLEAR));
					else
						send_request(random_item(REQ_UNUSED));
				end
			end else if (seg_kind <= 7) begin
				// burst of frames, then as many reads plus up to three extra reads
				repeat (seg_len) send_request(random_item(REQ_WRITE));
				repeat (seg_len + $urandom_range(0, 3)) send_request(random_item(REQ_READ));
			end else if (seg_kind == 8) begin
				repeat (seg_len) send_request(random_item(REQ_WRITE));
			end else begin
				repeat (seg_len / 4 + 1) begin
					if ($urandom_range(0, 1) != 0)
						send_request(random_item(REQ_UNUSED));
					else
						send_request(random_item(REQ_READ));
				end
			end
			segments++;
			if (segments % 5 == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	initial begin
		arst_n                <= 1'b0;
		req_bus.valid         <= 1'b0;
		req_bus.req_type      <= REQ_WRITE;
		req_bus.channel_count <= '0;
		req_bus.chan0         <= '0;
		req_bus.chan1         <= '0;
		req_bus.chan2         <= '0;
		req_bus.chan3         <= '0;
		req_bus.chan4         <= '0;
		req_bus.chan5         <= '0;
		req_bus.chan6         <= '0;
		req_bus.chan7         <= '0;
		rsp_bus.ready         <= 1'b0;
		ring_head   = 0;
		ring_tail   = 0;
		ring_count  = 0;
		mismatches  = 0;
		carried_out = 0;
		n_writes = 0; n_drops = 0; n_reads = 0;
		n_underruns = 0; n_clears = 0; n_refused = 0;
		req_gap_max   = 0;
		rsp_stall_max = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_ring_overwrite();
		test_random_traffic();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", expected_results.size()));
		$display("covered %0d responses: %0d writes (%0d overwrote the oldest), %0d reads",
			responses_seen, n_writes, n_drops, n_reads);
		$display("  %0d reads on an empty ring, %0d clears, %0d refused requests",
			n_underruns, n_clears, n_refused);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// response side backpressure
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, rsp_stall_max);
			if (stall != 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_bus.valid) @(posedge clk);
		end
	end

	initial responses_seen = 0;

	always @(posedge clk) begin
		pcm_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			responses_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = expected_results.pop_front();
				if (rsp_bus.accepted !== want.accepted)
					report_mismatch($sformatf("accepted %0b, want %0b",
						rsp_bus.accepted, want.accepted));
				if (rsp_bus.read_sample !== want.sample)
					report_mismatch($sformatf("read_sample %0d, want %0d",
						rsp_bus.read_sample, $signed(want.sample)));
				if (rsp_bus.underrun !== want.underrun)
					report_mismatch($sformatf("underrun %0b, want %0b",
						rsp_bus.underrun, want.underrun));
				if (rsp_bus.dropped !== want.dropped)
					report_mismatch($sformatf("dropped %0b, want %0b",
						rsp_bus.dropped, want.dropped));
				if (rsp_bus.fill_level !== want.fill)
					report_mismatch($sformatf("fill_level %0d, want %0d",
						rsp_bus.fill_level, want.fill));
			end
		end
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
